@@ hdl/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int PRIO_BITS    = 16;
    localparam int COUNT_W      = $clog2(DEPTH + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef struct packed {
        logic                           cmd;
        logic signed [PRIO_BITS-1:0]    prio;
        logic        [PAYLOAD_BITS-1:0] payload;
    } spq_in_t;

    typedef struct packed {
        logic                           removed_valid;
        logic signed [PRIO_BITS-1:0]    removed_prio;
        logic        [PAYLOAD_BITS-1:0] removed_payload;
        logic                           dropped;
        logic        [COUNT_W-1:0]      count;
    } spq_out_t;

    // One stored entry of the sorted row.
    typedef struct packed {
        logic signed [PRIO_BITS-1:0]    prio;
        logic        [PAYLOAD_BITS-1:0] payload;
    } spq_entry_t;

    // Operation broadcast to every cell for the current cycle.
    typedef struct packed {
        logic ins;
        logic del;
    } spq_ctl_t;

endpackage

`default_nettype wire

@@ hdl/spq_cell.sv @@
`default_nettype none

// One slot of the sorted row. On insert, decide locally from the neighbour's
// take flag whether to load the new entry, shift in the left entry, or hold.
// On delete, shift in the right entry.
module spq_cell (
    input  wire logic               aclk,
    input  wire spq_pkg::spq_ctl_t  ctl,
    input  wire spq_pkg::spq_entry_t new_entry,
    input  wire spq_pkg::spq_entry_t left_entry,
    input  wire spq_pkg::spq_entry_t right_entry,
    input  wire logic               left_take,
    input  wire logic               occupied,
    output spq_pkg::spq_entry_t     entry,
    output logic                    take
);
    import spq_pkg::*;

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // The new item belongs at or ahead of this slot.
    assign take  = !occupied || (entry_reg.prio <= new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins) begin
            if (take && !left_take) begin
                entry_next = new_entry;
            end else if (take) begin
                entry_next = left_entry;
            end
        end else if (ctl.del) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ hdl/sorted_priority_queue.sv @@
// Sorted priority queue, highest priority first, DEPTH entries.
// Input channel (s_valid / s_ready / s_data): one item per command. cmd
// insert places prio and payload ahead of the first stored entry whose
// priority is less than or equal to it, so equal priorities leave newest
// first; cmd delete removes the head entry.
// Result channel (m_valid / m_ready / m_data): exactly one result item per
// accepted item, carrying the removed entry (delete), the dropped flag
// (insert into a full queue) and the entry count after the operation.
// The result is registered: it is valid the cycle after the item is accepted.
// Throughput: one item per cycle; the row of cells inserts or shifts one
// entry per cycle, and the single result register sets the pace when the
// receiver stalls: s_ready stays high while that register is empty or
// being taken, and drops while a result waits unaccepted.
// Reset (aresetn low, synchronous): the queue empties and no result is
// pending; stored entries are not cleared, only the count is.
`default_nettype none

module sorted_priority_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire spq_pkg::spq_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output spq_pkg::spq_out_t      m_data
);
    import spq_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    spq_out_t           m_data_reg;
    spq_out_t           m_data_next;

    logic       accept;
    logic       full;
    logic       empty;
    spq_ctl_t   ctl;
    spq_entry_t new_entry;

    spq_entry_t cell_entry [DEPTH];
    logic       cell_take  [DEPTH];
    logic       cell_occ   [DEPTH];

    // Take a new item whenever the result register is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == COUNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    assign ctl.ins = accept && (s_data.cmd == CMD_INSERT) && !full;
    assign ctl.del = accept && (s_data.cmd == CMD_DELETE) && !empty;

    assign new_entry.prio    = s_data.prio;
    assign new_entry.payload = s_data.payload;

    // Row of cells: slot 0 is the head.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_entry_t left_e;
        spq_entry_t right_e;
        logic       left_t;

        assign cell_occ[i] = (COUNT_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign left_e = new_entry;
            assign left_t = 1'b0;
        end else begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_t = cell_take[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_e = cell_entry[i];
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_take   (left_t),
            .occupied    (cell_occ[i]),
            .entry       (cell_entry[i]),
            .take        (cell_take[i])
        );
    end

    // Advance the count; a refused insert or an empty delete holds it.
    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (ctl.del) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    // Build the result item; zero the removed fields unless a head is popped.
    always_comb begin
        m_data_next                 = m_data_reg;
        m_valid_next                = m_valid_reg && !m_ready;
        if (accept) begin
            m_valid_next                = 1'b1;
            m_data_next.removed_valid   = ctl.del;
            m_data_next.removed_prio    = ctl.del ? cell_entry[0].prio : '0;
            m_data_next.removed_payload = ctl.del ? cell_entry[0].payload : '0;
            m_data_next.dropped         = (s_data.cmd == CMD_INSERT) && full;
            m_data_next.count           = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Count never passes the row length.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // An accepted item always leaves a result behind.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted item produced no result");

    // A successful insert grows the queue by one.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins |=> (count_reg == COUNT_W'($past(count_reg) + COUNT_W'(1))))
        else $error("insert did not advance count");

    // The two head slots stay in priority order.
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= COUNT_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
        else $error("head entries out of order");

    // The reported count matches the queue once the result is shown.
    a_count_report: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_data_reg.count == count_reg))
        else $error("reported count differs from queue");

endmodule

`default_nettype wire

@@ tb/sv/spq_order_checker.sv @@
`timescale 1ns / 100ps

module spq_order_checker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire spq_pkg::spq_in_t  s_data,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire spq_pkg::spq_out_t m_data,
    output int                     mismatches,
    output int                     outstanding,
    output int                     checked,
    output int                     refused,
    output int                     empty_reads,
    output int                     peak_fill
);
    import spq_pkg::*;

    spq_entry_t sorted_row [DEPTH];
    int         fill;
    spq_out_t   awaited [$];
    spq_out_t   predicted;
    spq_out_t   oldest;

    initial begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
        refused     = 0;
        empty_reads = 0;
        peak_fill   = 0;
        fill        = 0;
    end

    // Apply one command to the private copy of the queue and give its result.
    task automatic predict_queue_op(input spq_in_t op, output spq_out_t res);
        int pos;
        res = '0;
        if (op.cmd == CMD_INSERT) begin
            if (fill >= DEPTH) begin
                res.dropped = 1'b1;
            end else begin
                // first slot whose priority is not above the new one
                pos = fill;
                for (int i = fill - 1; i >= 0; i--) begin
                    if ($signed(sorted_row[i].prio) <= $signed(op.prio))
                        pos = i;
                end
                for (int i = fill; i > pos; i--)
                    sorted_row[i] = sorted_row[i-1];
                sorted_row[pos].prio    = op.prio;
                sorted_row[pos].payload = op.payload;
                fill++;
            end
        end else if (fill > 0) begin
            res.removed_valid   = 1'b1;
            res.removed_prio    = sorted_row[0].prio;
            res.removed_payload = sorted_row[0].payload;
            for (int i = 1; i < fill; i++)
                sorted_row[i-1] = sorted_row[i];
            fill--;
        end
        res.count = COUNT_W'(fill);
    endtask

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill = 0;
            awaited.delete();
        end else begin
            // results are registered after their item is taken, so retire before adding
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %p", $time, m_data);
                end else begin
                    oldest = awaited.pop_front();
                    compare_field("removed_valid", oldest.removed_valid, m_data.removed_valid);
                    compare_field("removed_prio", $signed(oldest.removed_prio),
                                  $signed(m_data.removed_prio));
                    compare_field("removed_payload", oldest.removed_payload,
                                  m_data.removed_payload);
                    compare_field("dropped", oldest.dropped, m_data.dropped);
                    compare_field("count", oldest.count, m_data.count);
                    checked++;
                end
            end
            if (s_valid && s_ready) begin
                predict_queue_op(s_data, predicted);
                awaited.push_back(predicted);
                if (predicted.dropped)
                    refused++;
                if (s_data.cmd == CMD_DELETE && !predicted.removed_valid)
                    empty_reads++;
                if (fill > peak_fill)
                    peak_fill = fill;
            end
        end
        outstanding = awaited.size();
    end

endmodule

@@ tb/sv/sorted_priority_queue_tb.sv @@
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    spq_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    spq_out_t m_data;

    // Idling knobs, read by the sender task and the receiver process.
    int send_idle_pct;
    int recv_stall_pct;
    // Hold-off request handed to the receiver, which counts it down itself.
    int hold_req;
    int hold_left;

    int unsigned cycle_count;
    int mismatches;
    int outstanding;
    int checked;
    int refused;
    int empty_reads;
    int peak_fill;

    sorted_priority_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    spq_order_checker order_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .refused     (refused),
        .empty_reads (empty_reads),
        .peak_fill   (peak_fill)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Give up once the cycle budget is spent: a lost or stuck result ends here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("sorted_priority_queue_tb failed");
        $finish;
    end

    function automatic spq_in_t insert_op(input int prio, input int payload);
        spq_in_t op;
        op.cmd     = CMD_INSERT;
        op.prio    = prio[PRIO_BITS-1:0];
        op.payload = payload[PAYLOAD_BITS-1:0];
        return op;
    endfunction

    function automatic spq_in_t delete_op();
        spq_in_t op;
        // the priority and payload of a delete are ignored; toggle them anyway
        op     = insert_op($urandom, $urandom);
        op.cmd = CMD_DELETE;
        return op;
    endfunction

    // Random command: priorities lean on a narrow band, so that ties are common,
    // and on the two ends of the signed range.
    function automatic spq_in_t random_op(input int insert_pct);
        spq_in_t op;
        int      pick;
        int      level;
        pick = $urandom_range(99);
        if (pick < 35)
            level = int'($urandom_range(6)) - 3;
        else if (pick < 45)
            level = $urandom_range(1) ? 32767 - int'($urandom_range(1))
                                      : -32768 + int'($urandom_range(1));
        else
            level = $urandom;
        op = insert_op(level, $urandom);
        if ($urandom_range(99) >= insert_pct)
            op.cmd = CMD_DELETE;
        return op;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send(input spq_in_t op);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic random_run(input int insert_pct, input int n);
        repeat (n) send(random_op(insert_pct));
    endtask

    // Drop valid and wait for every outstanding result; sample away from the edge.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    // Receiver: stall at random, or hold off for a requested stretch.
    initial begin
        hold_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        s_valid        <= 1'b0;
        s_data         <= '0;
        m_ready        <= 1'b0;
        aresetn        <= 1'b0;
        hold_req       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: delete from empty, priority extremes, ties at head, middle
        // and tail (newest first), delete down to empty and past it, then an entry
        // below all others going to the tail.
        send(delete_op());
        send(insert_op(0, 16'h0000));
        send(insert_op(32767, 16'hFFFF));
        send(insert_op(-32768, 16'hAAAA));
        send(insert_op(0, 16'h5555));
        send(insert_op(-32768, 16'h1234));
        send(insert_op(32767, 16'h0001));
        repeat (7) send(delete_op());
        send(insert_op(1, 16'h00FF));
        send(delete_op());
        send(insert_op(-1, 16'hFF00));
        send(insert_op(-2, 16'h8001));
        send(delete_op());
        send(delete_op());
        drain();

        // Random: each idling phase fills the queue past full, churns, then drains.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default: begin
                    send_idle_pct  = 31;
                    recv_stall_pct = 31;
                end
            endcase
            random_run(80, 70);
            random_run(50, 60);
            random_run(25, 70);
            drain();
        end

        // Back-pressure: hold the result side off while items keep coming, so
        // the result register fills and s_ready drops; then pause until empty.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 60;
        random_run(85, 40);
        drain();

        // Leave the receiver open so any stray result is caught.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results; queue reached %0d entries.", checked, peak_fill);
        $display("Refused inserts on a full queue: %0d, deletes from an empty queue: %0d.",
                 refused, empty_reads);
        if (mismatches == 0)
            $display("sorted_priority_queue_tb passed");
        else
            $display("sorted_priority_queue_tb failed");
        $finish;
    end

endmodule
